>>> rtl/crc8fr_pkg.sv
package crc8fr_pkg;

    // Error kinds reported with every result
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_BAD_START   = 3'd1;
    localparam logic [2:0] ERR_BAD_SIZE    = 3'd2;
    localparam logic [2:0] ERR_BAD_COMMAND = 3'd3;
    localparam logic [2:0] ERR_BAD_CRC     = 3'd4;

    // Configuration register indexes
    localparam logic [7:0] REG_START_MARKER = 8'd0;
    localparam logic [7:0] REG_MIN_SIZE     = 8'd1;
    localparam logic [7:0] REG_MAX_SIZE     = 8'd2;
    localparam logic [7:0] REG_MAX_COMMAND  = 8'd3;

    // Configuration reset values
    localparam logic [7:0] START_MARKER_RST = 8'h00;
    localparam logic [7:0] MIN_SIZE_RST     = 8'd4;
    localparam logic [7:0] MAX_SIZE_RST     = 8'd32;
    localparam logic [7:0] MAX_COMMAND_RST  = 8'hFF;

    // CRC and framing constants
    localparam logic [7:0] CRC_POLY     = 8'h8C;
    localparam logic [7:0] CRC_INIT     = 8'h00;
    localparam logic [7:0] LEFT_NOT_SET = 8'hFF;
    localparam logic [7:0] SIZE_FLOOR   = 8'd2;
    localparam int         NUM_ARGS     = 4;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        byte_t start_marker;
        byte_t min_frame_size;
        byte_t max_frame_size;
        byte_t max_command;
    } cfg_t;

    typedef struct packed {
        logic       acknowledge;
        logic [2:0] error_kind;
        byte_t      frame_command;
        byte_t      argument_0;
        byte_t      argument_1;
        byte_t      argument_2;
        byte_t      argument_3;
        byte_t      frame_length;
    } result_t;

    // Reflected CRC-8 update over one byte, LSB first
    function automatic byte_t crc_update(input byte_t crc_in, input byte_t data_in);
        byte_t crc;
        byte_t data;
        logic  mix;
        crc  = crc_in;
        data = data_in;
        for (int i = 0; i < 8; i++)
        begin
            mix  = crc[0] ^ data[0];
            crc  = crc >> 1;
            if (mix)
            begin
                crc = crc ^ CRC_POLY;
            end
            data = data >> 1;
        end
        return crc;
    endfunction

endpackage

>>> rtl/crc8fr_parser.sv
module crc8fr_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_strobe,
    input  logic [7:0]        byte_in,
    input  crc8fr_pkg::cfg_t  cfg,
    output logic              res_valid,
    output crc8fr_pkg::result_t res
);
    import crc8fr_pkg::*;

    byte_t pos_reg, pos_next;
    byte_t left_reg, left_next;
    byte_t crc_reg, crc_next;
    byte_t size_reg, size_next;
    byte_t cmd_reg, cmd_next;
    byte_t arg_reg [NUM_ARGS];
    byte_t arg_next [NUM_ARGS];

    logic       done;
    logic       last;
    logic [2:0] err;

    // Decode one byte against the frame state
    always_comb
    begin
        pos_next  = pos_reg;
        left_next = left_reg;
        crc_next  = crc_reg;
        size_next = size_reg;
        cmd_next  = cmd_reg;
        for (int i = 0; i < NUM_ARGS; i++)
        begin
            arg_next[i] = arg_reg[i];
        end
        done = 1'b0;
        last = 1'b0;
        err  = ERR_NONE;

        if (pos_reg == 8'd0)
        begin
            if (byte_in != cfg.start_marker)
            begin
                err  = ERR_BAD_START;
                done = 1'b1;
            end
            else
            begin
                crc_next = crc_update(crc_reg, byte_in);
                pos_next = 8'd1;
            end
        end
        else if (pos_reg == 8'd1)
        begin
            size_next = byte_in;
            if (byte_in < SIZE_FLOOR || byte_in < cfg.min_frame_size ||
                byte_in > cfg.max_frame_size)
            begin
                err  = ERR_BAD_SIZE;
                done = 1'b1;
            end
            else
            begin
                left_next = byte_in - SIZE_FLOOR;
                if (left_next == 8'd0)
                begin
                    last = 1'b1;
                end
                else
                begin
                    crc_next = crc_update(crc_reg, byte_in);
                    pos_next = 8'd2;
                end
            end
        end
        else
        begin
            if (pos_reg == 8'd2)
            begin
                cmd_next = byte_in;
                if (byte_in > cfg.max_command)
                begin
                    err  = ERR_BAD_COMMAND;
                    done = 1'b1;
                end
            end
            if (!done)
            begin
                left_next = left_reg - 8'd1;
                if (left_next == 8'd0)
                begin
                    last = 1'b1;
                end
                else
                begin
                    // capture the first four argument bytes
                    if (pos_reg >= 8'd3 && pos_reg <= 8'd6)
                    begin
                        arg_next[2'(pos_reg - 8'd3)] = byte_in;
                    end
                    crc_next = crc_update(crc_reg, byte_in);
                    pos_next = pos_reg + 8'd1;
                end
            end
        end

        // Check the trailing CRC byte
        if (last)
        begin
            if (byte_in != crc_reg)
            begin
                err = ERR_BAD_CRC;
            end
            done = 1'b1;
        end
    end

    // Build the result from the updated frame fields
    assign res_valid         = byte_strobe && done;
    assign res.acknowledge   = (err == ERR_NONE);
    assign res.error_kind    = err;
    assign res.frame_command = cmd_next;
    assign res.argument_0    = arg_next[0];
    assign res.argument_1    = arg_next[1];
    assign res.argument_2    = arg_next[2];
    assign res.argument_3    = arg_next[3];
    assign res.frame_length  = size_next;

    // Advance the frame state, restart after every result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 8'd0;
            left_reg <= LEFT_NOT_SET;
            crc_reg  <= CRC_INIT;
            size_reg <= 8'd0;
            cmd_reg  <= 8'd0;
            for (int i = 0; i < NUM_ARGS; i++)
            begin
                arg_reg[i] <= 8'd0;
            end
        end
        else if (byte_strobe)
        begin
            if (done)
            begin
                pos_reg  <= 8'd0;
                left_reg <= LEFT_NOT_SET;
                crc_reg  <= CRC_INIT;
                size_reg <= 8'd0;
                cmd_reg  <= 8'd0;
                for (int i = 0; i < NUM_ARGS; i++)
                begin
                    arg_reg[i] <= 8'd0;
                end
            end
            else
            begin
                pos_reg  <= pos_next;
                left_reg <= left_next;
                crc_reg  <= crc_next;
                size_reg <= size_next;
                cmd_reg  <= cmd_next;
                for (int i = 0; i < NUM_ARGS; i++)
                begin
                    arg_reg[i] <= arg_next[i];
                end
            end
        end
    end

endmodule

>>> rtl/crc8_framed_serial_receiver.sv
// The byte that ends or rejects a frame has its result registered in the output
// or skid register. One byte per cycle while in_stall is low; the frame state and
// the unrolled CRC-8 update are combinational between the frame registers.
// An output register plus a skid register hold up to two results; in_stall rises
// only while the skid register is occupied.
// Reset (rst_n low, asynchronous) clears the frame state and restores register defaults.
module crc8_framed_serial_receiver (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       acknowledge,
    output logic [2:0] error_kind,
    output logic [7:0] frame_command,
    output logic [7:0] argument_0,
    output logic [7:0] argument_1,
    output logic [7:0] argument_2,
    output logic [7:0] argument_3,
    output logic [7:0] frame_length,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import crc8fr_pkg::*;

    cfg_t    cfg_reg;
    result_t out_reg;
    result_t skid_reg;
    result_t res;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    res_valid;
    logic    in_take;
    logic    out_take;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_take   = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    // Hold the configuration registers; ignore unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_marker   <= START_MARKER_RST;
            cfg_reg.min_frame_size <= MIN_SIZE_RST;
            cfg_reg.max_frame_size <= MAX_SIZE_RST;
            cfg_reg.max_command    <= MAX_COMMAND_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_START_MARKER: cfg_reg.start_marker   <= cfg_data;
                REG_MIN_SIZE:     cfg_reg.min_frame_size <= cfg_data;
                REG_MAX_SIZE:     cfg_reg.max_frame_size <= cfg_data;
                REG_MAX_COMMAND:  cfg_reg.max_command    <= cfg_data;
                default:          ;
            endcase
        end
    end

    crc8fr_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_strobe (in_take),
        .byte_in     (rx_byte),
        .cfg         (cfg_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Move payloads alongside the valid flags
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign acknowledge   = out_reg.acknowledge;
    assign error_kind    = out_reg.error_kind;
    assign frame_command = out_reg.frame_command;
    assign argument_0    = out_reg.argument_0;
    assign argument_1    = out_reg.argument_1;
    assign argument_2    = out_reg.argument_2;
    assign argument_3    = out_reg.argument_3;
    assign frame_length  = out_reg.frame_length;

endmodule

>>> sim/frame_result_checker.sv
module frame_result_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       acknowledge,
    input  logic [2:0] error_kind,
    input  logic [7:0] frame_command,
    input  logic [7:0] argument_0,
    input  logic [7:0] argument_1,
    input  logic [7:0] argument_2,
    input  logic [7:0] argument_3,
    input  logic [7:0] frame_length,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         pending,
    output logic       frame_open,
    output int         acks,
    output int         nacks
);
    timeunit 1ns;
    timeprecision 1ps;

    import crc8fr_pkg::*;

    // Register copy and frame parser state
    cfg_t    limits;
    byte_t   position;
    byte_t   remaining;
    byte_t   crc_acc;
    byte_t   size_seen;
    byte_t   cmd_seen;
    byte_t   args_seen [NUM_ARGS];

    // Replies (ACK/NACK) the block still owes, oldest first
    result_t owed_replies [$];

    int      failures = 0;
    int      owed = 0;
    int      ack_total = 0;
    int      nack_total = 0;

    assign fail_count = failures;
    assign pending    = owed;
    assign frame_open = (position != 8'd0);
    assign acks       = ack_total;
    assign nacks      = nack_total;

    // Reflected CRC-8: fold the byte in first, then eight shifts
    function automatic byte_t crc8_fold(input byte_t acc, input byte_t d);
        byte_t x;
        x = acc ^ d;
        for (int k = 0; k < 8; k++)
        begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    task automatic restart_frame();
        position  = 8'd0;
        remaining = LEFT_NOT_SET;
        crc_acc   = CRC_INIT;
        size_seen = 8'd0;
        cmd_seen  = 8'd0;
        for (int k = 0; k < NUM_ARGS; k++)
        begin
            args_seen[k] = 8'd0;
        end
    endtask

    task automatic apply_reg_write(input byte_t idx, input byte_t val);
        case (idx)
            REG_START_MARKER: limits.start_marker   = val;
            REG_MIN_SIZE:     limits.min_frame_size = val;
            REG_MAX_SIZE:     limits.max_frame_size = val;
            REG_MAX_COMMAND:  limits.max_command    = val;
            default:          ;
        endcase
    endtask

    // Advance the frame parser by one byte; report a reply when the frame ends
    task automatic parse_rx_byte(input byte_t b, output bit ended, output result_t reply);
        bit         last;
        logic [2:0] err;
        ended = 1'b0;
        last  = 1'b0;
        err   = ERR_NONE;
        reply = '0;

        if (position == 8'd0)
        begin
            if (b != limits.start_marker)
            begin
                err   = ERR_BAD_START;
                ended = 1'b1;
            end
            else
            begin
                crc_acc  = crc8_fold(crc_acc, b);
                position = 8'd1;
            end
        end
        else if (position == 8'd1)
        begin
            size_seen = b;
            if (b < SIZE_FLOOR || b < limits.min_frame_size || b > limits.max_frame_size)
            begin
                err   = ERR_BAD_SIZE;
                ended = 1'b1;
            end
            else
            begin
                remaining = b - SIZE_FLOOR;
                if (remaining == 8'd0)
                begin
                    last = 1'b1;
                end
                else
                begin
                    crc_acc  = crc8_fold(crc_acc, b);
                    position = 8'd2;
                end
            end
        end
        else
        begin
            // Command byte is range-checked even when it doubles as the CRC
            if (position == 8'd2)
            begin
                cmd_seen = b;
                if (b > limits.max_command)
                begin
                    err   = ERR_BAD_COMMAND;
                    ended = 1'b1;
                end
            end
            if (!ended)
            begin
                remaining = remaining - 8'd1;
                if (remaining == 8'd0)
                begin
                    last = 1'b1;
                end
                else
                begin
                    if (position >= 8'd3 && position <= 8'd6)
                    begin
                        args_seen[2'(position - 8'd3)] = b;
                    end
                    crc_acc  = crc8_fold(crc_acc, b);
                    position = position + 8'd1;
                end
            end
        end

        if (last)
        begin
            if (b != crc_acc)
            begin
                err = ERR_BAD_CRC;
            end
            ended = 1'b1;
        end

        if (ended)
        begin
            reply.acknowledge   = (err == ERR_NONE);
            reply.error_kind    = err;
            reply.frame_command = cmd_seen;
            reply.argument_0    = args_seen[0];
            reply.argument_1    = args_seen[1];
            reply.argument_2    = args_seen[2];
            reply.argument_3    = args_seen[3];
            reply.frame_length  = size_seen;
            restart_frame();
        end
    endtask

    task automatic compare_field(input string name, input int unsigned exp_v,
                                 input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            failures++;
        end
    endtask

    // Watch both channels and the register port at every edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        bit      ended;
        result_t predicted;
        result_t oldest;
        if (!rst_n)
        begin
            limits.start_marker   = START_MARKER_RST;
            limits.min_frame_size = MIN_SIZE_RST;
            limits.max_frame_size = MAX_SIZE_RST;
            limits.max_command    = MAX_COMMAND_RST;
            restart_frame();
            owed_replies.delete();
            owed = 0;
        end
        else
        begin
            // Compare an accepted reply with the oldest one owed
            if (out_valid && !out_stall)
            begin
                if (acknowledge)
                begin
                    ack_total++;
                end
                else
                begin
                    nack_total++;
                end
                if (owed_replies.size() == 0)
                begin
                    $error("reply with nothing owed: ack %0b kind %0d", acknowledge, error_kind);
                    failures++;
                end
                else
                begin
                    oldest = owed_replies.pop_front();
                    compare_field("acknowledge", oldest.acknowledge, acknowledge);
                    compare_field("error_kind", oldest.error_kind, error_kind);
                    compare_field("frame_command", oldest.frame_command, frame_command);
                    compare_field("argument_0", oldest.argument_0, argument_0);
                    compare_field("argument_1", oldest.argument_1, argument_1);
                    compare_field("argument_2", oldest.argument_2, argument_2);
                    compare_field("argument_3", oldest.argument_3, argument_3);
                    compare_field("frame_length", oldest.frame_length, frame_length);
                end
            end

            // Predict the reply, if any, for an accepted byte
            if (in_valid && !in_stall)
            begin
                parse_rx_byte(rx_byte, ended, predicted);
                if (ended)
                begin
                    owed_replies.push_back(predicted);
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                apply_reg_write(cfg_index, cfg_data);
            end

            owed = owed_replies.size();
        end
    end

endmodule

>>> sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import crc8fr_pkg::*;

    localparam int    CYCLE_LIMIT    = 200000;
    localparam int    HOLD_CYCLES    = 300;
    localparam int    SETTLE_CYCLES  = 4;
    localparam int    NUM_PHASES     = 6;
    localparam int    PRESSURE_PHASE = 4;
    localparam byte_t REG_UNUSED     = 8'd7;

    // Per-phase register settings, idle rates and byte budgets
    byte_t phase_marker [NUM_PHASES] = '{8'hA5, 8'h00, 8'hFF, 8'h00, 8'h3C, 8'h81};
    byte_t phase_min    [NUM_PHASES] = '{8'd4, 8'd2, 8'd3, 8'd5, 8'd9, 8'd255};
    byte_t phase_max    [NUM_PHASES] = '{8'd16, 8'd12, 8'd10, 8'd20, 8'd6, 8'd255};
    byte_t phase_cmd    [NUM_PHASES] = '{8'hFF, 8'h7F, 8'hF0, 8'h00, 8'hFF, 8'h00};
    int    phase_gap    [NUM_PHASES] = '{0, 69, 0, 24, 0, 24};
    int    phase_stall  [NUM_PHASES] = '{0, 0, 69, 24, 0, 24};
    int    phase_budget [NUM_PHASES] = '{140, 140, 140, 140, 140, 520};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       acknowledge;
    logic [2:0] error_kind;
    logic [7:0] frame_command;
    logic [7:0] argument_0;
    logic [7:0] argument_1;
    logic [7:0] argument_2;
    logic [7:0] argument_3;
    logic [7:0] frame_length;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_index = 8'd0;
    logic [7:0] cfg_data = 8'd0;

    int         fail_count;
    int         pending;
    logic       frame_open;
    int         acks;
    int         nacks;

    int         cycles = 0;
    int         bytes_sent = 0;
    int         settings_used = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    bit         hold_req = 1'b0;
    bit         hold_done = 1'b0;

    // Register values as last written, used to shape frames
    byte_t      cur_marker = START_MARKER_RST;
    byte_t      cur_min = MIN_SIZE_RST;
    byte_t      cur_max = MAX_SIZE_RST;
    byte_t      cur_cmd = MAX_COMMAND_RST;

    crc8_framed_serial_receiver u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .acknowledge   (acknowledge),
        .error_kind    (error_kind),
        .frame_command (frame_command),
        .argument_0    (argument_0),
        .argument_1    (argument_1),
        .argument_2    (argument_2),
        .argument_3    (argument_3),
        .frame_length  (frame_length),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    frame_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .acknowledge   (acknowledge),
        .error_kind    (error_kind),
        .frame_command (frame_command),
        .argument_0    (argument_0),
        .argument_1    (argument_1),
        .argument_2    (argument_2),
        .argument_3    (argument_3),
        .frame_length  (frame_length),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .frame_open    (frame_open),
        .acks          (acks),
        .nacks         (nacks)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("crc8_framed_serial_receiver regression: fail");
            $finish;
        end
    end

    // Reply side: random stall, plus one long hold-off when requested
    always
    begin
        @(posedge clk);
        if (hold_req && !hold_done)
        begin
            out_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_done = 1'b1;
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Offer one byte and hold it until the transaction completes; returns at that edge
    task automatic push_byte(input byte_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(negedge clk);
        while (in_stall)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        bytes_sent++;
    endtask

    task automatic write_reg(input byte_t idx, input byte_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        while (!cfg_ready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic write_limits(input byte_t marker, input byte_t lo, input byte_t hi,
                                input byte_t cmd);
        write_reg(REG_START_MARKER, marker);
        write_reg(REG_MIN_SIZE, lo);
        write_reg(REG_MAX_SIZE, hi);
        write_reg(REG_MAX_COMMAND, cmd);
        // Stray index must leave every register alone
        write_reg(REG_UNUSED, byte_t'($urandom_range(255)));
        cfg_valid <= 1'b0;
        cur_marker = marker;
        cur_min    = lo;
        cur_max    = hi;
        cur_cmd    = cmd;
        settings_used++;
    endtask

    // Finish any open frame, then wait until every reply is out and the block is quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (frame_open)
        begin
            @(posedge clk);
            push_byte(byte_t'($urandom_range(255)));
            in_valid <= 1'b0;
            @(negedge clk);
        end
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        @(posedge clk);
    endtask

    // Send a whole frame of the given size; optionally corrupt the CRC byte
    task automatic send_frame(input byte_t size, input byte_t cmd, input bit corrupt_crc,
                              input bit extreme_fill);
        byte_t bytes_q [$];
        byte_t acc;
        bytes_q.push_back(cur_marker);
        bytes_q.push_back(size);
        if (size >= 8'd4)
        begin
            bytes_q.push_back(cmd);
        end
        for (int k = 4; k < size; k++)
        begin
            if (extreme_fill)
            begin
                bytes_q.push_back((k % 2) ? 8'hFF : 8'h00);
            end
            else
            begin
                bytes_q.push_back(byte_t'($urandom_range(255)));
            end
        end
        if (size >= 8'd3)
        begin
            acc = CRC_INIT;
            foreach (bytes_q[k])
            begin
                acc = crc_update(acc, bytes_q[k]);
            end
            if (corrupt_crc)
            begin
                acc = acc ^ byte_t'($urandom_range(1, 255));
            end
            bytes_q.push_back(acc);
        end
        foreach (bytes_q[k])
        begin
            push_byte(bytes_q[k]);
        end
    endtask

    // Mostly well-formed frames with random content, the rest broken frames and noise
    task automatic random_frame();
        int    pick;
        int    lo;
        int    span;
        int    n;
        byte_t size;
        byte_t cmd;
        if (cur_min <= cur_max && cur_max >= SIZE_FLOOR)
        begin
            lo   = (cur_min < SIZE_FLOOR) ? SIZE_FLOOR : cur_min;
            span = cur_max - lo;
            if ($urandom_range(9) == 0)
            begin
                size = byte_t'(lo + $urandom_range(span));
            end
            else
            begin
                size = byte_t'(lo + $urandom_range((span < 8) ? span : 8));
            end
        end
        else
        begin
            size = byte_t'($urandom_range(2, 20));
        end
        cmd = byte_t'($urandom_range(cur_cmd));
        if ($urandom_range(4) == 0)
        begin
            cmd = $urandom_range(1) ? cur_cmd : 8'h00;
        end

        pick = $urandom_range(99);
        if (pick < 55)
        begin
            send_frame(size, cmd, 1'b0, $urandom_range(4) == 0);
        end
        else if (pick < 70)
        begin
            send_frame(size, cmd, 1'b1, 1'b0);
        end
        else if (pick < 78 && cur_cmd != 8'hFF && size >= 8'd3)
        begin
            // Command above the limit ends the frame at once
            push_byte(cur_marker);
            push_byte(size);
            push_byte(byte_t'($urandom_range(cur_cmd + 1, 255)));
        end
        else if (pick < 86)
        begin
            push_byte(cur_marker);
            case ($urandom_range(3))
                0: push_byte(byte_t'($urandom_range(1)));
                1: push_byte((cur_min > SIZE_FLOOR) ? cur_min - 8'd1 : 8'd1);
                2: push_byte((cur_max < 8'hFF) ? cur_max + 8'd1 : 8'd0);
                default: push_byte(byte_t'($urandom_range(255)));
            endcase
        end
        else if (pick < 93)
        begin
            push_byte(cur_marker ^ byte_t'($urandom_range(1, 255)));
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n) push_byte(byte_t'($urandom_range(255)));
        end
    endtask

    initial
    begin : stimulus
        int    start_count;
        byte_t two_marker;
        two_marker = 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default registers: bad start, sizes 0, 1 and above the limit, top command
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h01);
        push_byte(8'h00);
        push_byte(8'd33);
        send_frame(8'd4, 8'hFF, 1'b0, 1'b0);
        send_frame(8'd4, 8'h00, 1'b1, 1'b0);
        settle();

        // Pick a start byte whose CRC is 2 so a two-byte frame passes
        for (int m = 0; m < 256; m++)
        begin
            if (crc_update(CRC_INIT, byte_t'(m)) == SIZE_FLOOR)
            begin
                two_marker = byte_t'(m);
            end
        end
        write_limits(two_marker, SIZE_FLOOR, 8'hFF, 8'hFF);
        send_frame(8'd2, 8'h00, 1'b0, 1'b0);
        send_frame(8'd3, 8'h00, 1'b0, 1'b0);
        send_frame(8'd9, 8'h00, 1'b0, 1'b1);
        settle();

        // Command limit: one just above, one at the limit
        write_limits(8'h5A, SIZE_FLOOR, 8'hFF, 8'h80);
        push_byte(8'h5A);
        push_byte(8'd5);
        push_byte(8'h81);
        send_frame(8'd4, 8'h80, 1'b0, 1'b0);
        settle();

        // Random phases over several register settings and idle patterns
        phase_marker[3] = byte_t'($urandom_range(255));
        phase_cmd[3]    = byte_t'($urandom_range(255));
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_limits(phase_marker[p], phase_min[p], phase_max[p], phase_cmd[p]);
            send_idle_pct = phase_gap[p];
            stall_pct     = phase_stall[p];
            if (p == PRESSURE_PHASE)
            begin
                hold_req = 1'b1;
            end
            start_count = bytes_sent;
            while (bytes_sent - start_count < phase_budget[p])
            begin
                random_frame();
            end
            settle();
        end

        $display("covered %0d received bytes under %0d register settings",
                 bytes_sent, settings_used);
        $display("frames acknowledged %0d, rejected %0d", acks, nacks);
        if (fail_count == 0)
        begin
            $display("crc8_framed_serial_receiver regression: pass");
        end
        else
        begin
            $display("crc8_framed_serial_receiver regression: fail");
        end
        $finish;
    end

endmodule

>>> crc8_framed_serial_receiver.f
rtl/crc8fr_pkg.sv
rtl/crc8fr_parser.sv
rtl/crc8_framed_serial_receiver.sv
sim/frame_result_checker.sv
sim/tb_top.sv
